[design/cmm_pkg.sv]
// ----------------------------------------------------------------------------
// cmm_pkg: shared types and constants for the complex matrix multiply unit
// Store geometry, stream word layout and the load word passed front to back.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int MAX_DIM     = 4;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam int POS_W   = 2;   // row / col field width
    localparam int ELEM_W  = 16;  // Q2.14 component
    localparam int WORD_W  = 2 * ELEM_W;
    localparam int PROD_W  = 2 * ELEM_W;      // 16x16 product
    localparam int TERM_W  = PROD_W + 1;      // difference / sum of two products
    localparam int ACC_W   = 35;              // Q7.28 result
    localparam int CFG_W   = 3;

    localparam int S_DATA_W = 72;  // 68 bits of fields, padded to bytes
    localparam int M_DATA_W = 80;  // 74 bits of fields, padded to bytes

    // One load word as it waits in the queue
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              wr_en;   // position lies inside the store
        logic              start;   // last load, run the multiply after it
        logic [WORD_W-1:0] left_word;   // re in upper half, im in lower half
        logic [WORD_W-1:0] right_word;
    } t_load;

    // Tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastj;
        logic             last_out;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_tag;

endpackage

[design/cmm_front.sv]
// ----------------------------------------------------------------------------
// cmm_front: load intake
// Unpacks incoming words, classifies position and start flag, and holds them
// in a two-entry queue for the multiply engine.
// ----------------------------------------------------------------------------
module cmm_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [cmm_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                     i_s_tlast,
    output cmm_pkg::t_load           o_head,
    output logic                     o_head_valid,
    input  logic                     i_pop
);
    import cmm_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    t_load             r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_cnt;

    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    t_load            in_load;
    logic             push;
    logic             pop;

    // Repack each element with re in the upper half, im in the lower half
    always_comb begin
        row = i_s_tdata[1:0];
        col = i_s_tdata[3:2];
        in_load.idx        = IDX_W'(IDX_W'(row) * IDX_W'(MAX_DIM) + IDX_W'(col));
        in_load.wr_en      = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
        in_load.start      = i_s_tlast;
        in_load.left_word  = {i_s_tdata[19:4], i_s_tdata[35:20]};
        in_load.right_word = {i_s_tdata[51:36], i_s_tdata[67:52]};
    end

    assign o_s_tready   = (int'(r_cnt) < QDEPTH);
    assign push         = i_s_tvalid && o_s_tready;
    assign o_head_valid = (r_cnt != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[design/cmm_back.sv]
// ----------------------------------------------------------------------------
// cmm_back: store and multiply engine
// Writes loads into the two element stores; on a start flag sweeps r, c, j
// through one pipelined complex multiply-accumulate and emits each product.
// ----------------------------------------------------------------------------
module cmm_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cmm_pkg::t_load           i_head,
    input  logic                     i_head_valid,
    output logic                     o_pop,
    input  logic [cmm_pkg::DIM_W-1:0] i_nm1,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [cmm_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                     o_m_tlast
);
    import cmm_pkg::*;

    logic [WORD_W-1:0] left_mem  [STORE_DEPTH];
    logic [WORD_W-1:0] right_mem [STORE_DEPTH];

    logic              r_busy;
    logic [DIM_W-1:0]  r_nm1;
    logic [DIM_W-1:0]  r_r;
    logic [DIM_W-1:0]  r_c;
    logic [DIM_W-1:0]  r_j;

    t_tag              r_s1;
    t_tag              r_s2;
    t_tag              r_s3;
    logic [WORD_W-1:0] r_l_rd;
    logic [WORD_W-1:0] r_r_rd;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [TERM_W-1:0] r_t_re, r_t_im;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;

    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_row;
    logic [POS_W-1:0]  r_out_col;
    logic [ACC_W-1:0]  r_out_re;
    logic [ACC_W-1:0]  r_out_im;
    logic              r_out_last;

    logic              en;
    logic [IDX_W-1:0]  idx_l;
    logic [IDX_W-1:0]  idx_r;
    logic signed [ACC_W-1:0] n_acc_re, n_acc_im;

    // Whole pipeline advances whenever the output register can take a word
    assign en    = !r_out_valid || i_m_tready;
    assign o_pop = i_head_valid && !r_busy;

    assign idx_l = IDX_W'(IDX_W'(r_r) * IDX_W'(MAX_DIM) + IDX_W'(r_j));
    assign idx_r = IDX_W'(IDX_W'(r_j) * IDX_W'(MAX_DIM) + IDX_W'(r_c));

    // Element stores: one write port from the queue, one registered read each
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.wr_en) begin
            left_mem[i_head.idx]  <= i_head.left_word;
            right_mem[i_head.idx] <= i_head.right_word;
        end
        if (en) begin
            r_l_rd <= left_mem[idx_l];
            r_r_rd <= right_mem[idx_r];
        end
    end

    // Index sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_nm1  <= '0;
            r_r    <= '0;
            r_c    <= '0;
            r_j    <= '0;
        end else if (o_pop && i_head.start) begin
            r_busy <= 1'b1;
            r_nm1  <= i_nm1;
            r_r    <= '0;
            r_c    <= '0;
            r_j    <= '0;
        end else if (en && r_busy) begin
            if (r_j == r_nm1) begin
                r_j <= '0;
                if (r_c == r_nm1) begin
                    r_c <= '0;
                    if (r_r == r_nm1) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_r <= r_r + 1'b1;
                    end
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // Tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (en) begin
            r_s1.valid    <= r_busy;
            r_s1.first    <= (r_j == '0);
            r_s1.lastj    <= (r_j == r_nm1);
            r_s1.last_out <= (r_r == r_nm1) && (r_c == r_nm1);
            r_s1.row      <= POS_W'(r_r);
            r_s1.col      <= POS_W'(r_c);
            r_s2          <= r_s1;
            r_s3          <= r_s2;
        end
    end

    always_comb begin
        n_acc_re = (r_s3.first ? '0 : r_acc_re) + ACC_W'(r_t_re);
        n_acc_im = (r_s3.first ? '0 : r_acc_im) + ACC_W'(r_t_im);
    end

    // Datapath: products, combine, accumulate
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_rr <= $signed(r_l_rd[31:16]) * $signed(r_r_rd[31:16]);
            r_p_ii <= $signed(r_l_rd[15:0])  * $signed(r_r_rd[15:0]);
            r_p_ri <= $signed(r_l_rd[31:16]) * $signed(r_r_rd[15:0]);
            r_p_ir <= $signed(r_l_rd[15:0])  * $signed(r_r_rd[31:16]);
            r_t_re <= TERM_W'(r_p_rr) - TERM_W'(r_p_ii);
            r_t_im <= TERM_W'(r_p_ri) + TERM_W'(r_p_ir);
            if (r_s3.valid) begin
                r_acc_re <= n_acc_re;
                r_acc_im <= n_acc_im;
            end
            if (r_s3.valid && r_s3.lastj) begin
                r_out_row  <= r_s3.row;
                r_out_col  <= r_s3.col;
                r_out_re   <= n_acc_re;
                r_out_im   <= n_acc_im;
                r_out_last <= r_s3.last_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s3.valid && r_s3.lastj;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(M_DATA_W - 2 * POS_W - 2 * ACC_W){1'b0}},
                         r_out_im, r_out_re, r_out_col, r_out_row};

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_busy)
        else $error("load taken while multiply runs");

    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && !r_busy |=> !r_s1.valid)
        else $error("step issued while sequencer idle");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_row == r_out_col)
        else $error("final product not on the diagonal");

endmodule

[design/complex_matrix_multiply_unit.sv]
// ----------------------------------------------------------------------------
// complex_matrix_multiply_unit: complex square matrix product, L times R
// Loads Q2.14 elements of both matrices, then on the last load emits every
// element of the n x n product in row-major order as exact Q7.28 sums.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Width  Contents
//  s_axis    in   72     tdata: row[1:0] col[3:2] left_re[19:4] left_im[35:20]
//                        right_re[51:36] right_im[67:52]; tlast: final_load
//  m_axis    out  80     tdata: out_row[1:0] out_col[3:2] prod_re[38:4]
//                        prod_im[73:39]; tlast: last_out
//  cfg       in   3      size_in_use, written when i_cfg_wr_en is high
//
//  Cycles: a load word is taken every cycle while the two-entry queue has room.
//  A final load starts a sweep of n*n*n steps through one complex
//  multiply-accumulate, one step per cycle unless m_axis_tready stalls it;
//  each product leaves the output register once its n steps of j are summed.
//  The stores have one read port each, which sets one step per cycle.
//  Reset: synchronous, active low; clears queue, sequencer and output valid;
//  size_in_use returns to 4. Stores are not cleared.
//  Stalls: m_axis_tready low freezes the product pipeline; loads keep
//  queuing until the queue fills, and wait there until the sweep ends.
//
module complex_matrix_multiply_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cmm_pkg::S_DATA_W-1:0]  s_axis_tdata,  // row, col, left_re,
                                                         // left_im, right_re, right_im
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cmm_pkg::M_DATA_W-1:0]  m_axis_tdata,  // out_row, out_col,
                                                         // prod_re, prod_im
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_wr_en,
    input  logic [cmm_pkg::CFG_W-1:0]     i_cfg_wr_data
);
    import cmm_pkg::*;

    logic [CFG_W-1:0] r_size;
    logic [DIM_W-1:0] nm1;
    t_load            head;
    logic             head_valid;
    logic             pop;

    // Size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CFG_W'(4);
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    // Clamp size to 1..MAX_DIM, hand the engine n-1
    always_comb begin
        if (r_size == '0) begin
            nm1 = '0;
        end else if (int'(r_size) > MAX_DIM) begin
            nm1 = DIM_W'(MAX_DIM - 1);
        end else begin
            nm1 = DIM_W'(r_size - 1'b1);
        end
    end

    cmm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    cmm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .i_nm1        (nm1),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tlast    (m_axis_tlast)
    );

endmodule
